/* rtl/c3cf_pkg.sv */
// ----------------------------------------------------------------------------
// c3cf_pkg
// Shared types, constants and codes for the 3x3 clamp filter.
// ----------------------------------------------------------------------------
package c3cf_pkg;

    // Geometry and arithmetic
    localparam int MAX_WIDTH  = 1024;
    localparam int TAP_BITS   = 7;
    localparam int NUM_TAPS   = 9;
    localparam int LB_AW      = $clog2(MAX_WIDTH);
    localparam int CFG_W_W    = 11;                 // image_width register
    localparam int WCMP_W     = (LB_AW + 1 > CFG_W_W) ? LB_AW + 1 : CFG_W_W;
    localparam int HEIGHT_W   = 16;
    localparam int ROW_W      = HEIGHT_W + 1;       // row runs to height + 1 in flush
    localparam int PIX_W      = 8;
    localparam int SCALE_W    = 16;
    localparam int FRAC_BITS  = 12;
    localparam int TAPS_W     = NUM_TAPS * TAP_BITS;
    localparam int TERM_W     = PIX_W + 1 + TAP_BITS;
    localparam int ACC_W      = TERM_W + $clog2(NUM_TAPS);
    localparam int PROD_W     = ACC_W + SCALE_W;
    localparam int K_W        = $clog2(NUM_TAPS);
    localparam int LEVEL_MAX  = 255;

    // Configuration port
    localparam int CFG_DATA_W = TAPS_W;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_TAPS  = 2'd0,
        REG_SCALE_FACTOR = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } t_cfg_reg;

    // Reset values
    localparam logic [TAPS_W-1:0]   TAPS_RST   = TAPS_W'(64'd268435456);
    localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(4096);
    localparam logic [WCMP_W-1:0]   WIDTH_RST  = WCMP_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

    // Input func codes
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_PAD   = 1'b1;

    // Payloads
    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] red;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             last_of_image;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_MAC,
        S_SCALE,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic mac;
        logic scale;
        logic emit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic has_out;
        logic mac_done;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/c3cf_ctrl.sv */
// ----------------------------------------------------------------------------
// c3cf_ctrl
// Sequencer: accept, window update, nine tap MAC steps, scale, emit.
// ----------------------------------------------------------------------------
module c3cf_ctrl
    import c3cf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SHIFT;
            end
            S_SHIFT: begin
                n_state = i_status.has_out ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                if (i_status.mac_done) n_state = S_SCALE;
            end
            S_SCALE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SHIFT: o_cmd.shift = 1'b1;
            S_MAC:   o_cmd.mac   = 1'b1;
            S_SCALE: o_cmd.scale = 1'b1;
            S_EMIT:  o_cmd.emit  = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/c3cf_datapath.sv */
// ----------------------------------------------------------------------------
// c3cf_datapath
// Configuration registers, line buffers, 3x3 window, shared MAC unit,
// scale multiplier, clamp and output register.
// ----------------------------------------------------------------------------
module c3cf_datapath
    import c3cf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // streams
    input  t_in_item              i_in_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    // control
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status
);

    // Configuration registers (width and height held as effective values)
    logic [TAPS_W-1:0]          r_taps;
    logic signed [SCALE_W-1:0]  r_scale;
    logic [WCMP_W-1:0]          r_w;
    logic [HEIGHT_W-1:0]        r_h;

    // Position of the next input transaction
    logic [LB_AW-1:0]           r_col;
    logic [ROW_W-1:0]           r_row;

    // Captured transaction
    logic [LB_AW-1:0]           r_x;
    logic [ROW_W-1:0]           r_y;
    logic [PIX_W-1:0]           r_v;

    // Line buffers and their read registers
    logic [PIX_W-1:0]           r_lb_one [MAX_WIDTH];
    logic [PIX_W-1:0]           r_lb_two [MAX_WIDTH];
    logic [PIX_W-1:0]           r_one_rd;
    logic [PIX_W-1:0]           r_two_rd;

    // Window, output coordinates, MAC
    logic [PIX_W-1:0]           r_win [3][3];
    logic [LB_AW-1:0]           r_ox;
    logic [ROW_W-1:0]           r_oy;
    logic                       r_last;
    logic [K_W-1:0]             r_k;
    logic [1:0]                 r_tr;
    logic [1:0]                 r_tc;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [PROD_W-1:0]   r_prod;

    // Output register
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic [CFG_W_W-1:0]         cfg_w_raw;
    logic [HEIGHT_W-1:0]        cfg_h_raw;
    logic [LB_AW-1:0]           x_eff;
    logic [LB_AW-1:0]           w_m1;
    logic [ROW_W-1:0]           h_ext;
    logic [WCMP_W-1:0]          col_inc;
    logic [LB_AW-1:0]           n_ox;
    logic [ROW_W-1:0]           n_oy;
    logic                       n_has_out;
    logic                       n_last;
    logic signed [TAP_BITS-1:0] tap_arr [NUM_TAPS];
    logic [2:0]                 row_ok;
    logic [2:0]                 col_ok;
    logic [PIX_W-1:0]           pix_sel;
    logic signed [TERM_W-1:0]   term;
    logic signed [PROD_W-1:0]   n_prod;
    logic [PIX_W-1:0]           level;

    assign cfg_w_raw = i_cfg_data[CFG_W_W-1:0];
    assign cfg_h_raw = i_cfg_data[HEIGHT_W-1:0];

    // Configuration writes; geometry writes restart the image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps  <= TAPS_RST;
            r_scale <= SCALE_RST;
            r_w     <= WIDTH_RST;
            r_h     <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_KERNEL_TAPS:  r_taps  <= i_cfg_data[TAPS_W-1:0];
                REG_SCALE_FACTOR: r_scale <= i_cfg_data[SCALE_W-1:0];
                REG_IMAGE_WIDTH: begin
                    priority if (cfg_w_raw == '0) begin
                        r_w <= WCMP_W'(1);
                    end else if (WCMP_W'(cfg_w_raw) > WCMP_W'(MAX_WIDTH)) begin
                        r_w <= WCMP_W'(MAX_WIDTH);
                    end else begin
                        r_w <= WCMP_W'(cfg_w_raw);
                    end
                end
                REG_IMAGE_HEIGHT: r_h <= (cfg_h_raw == '0) ? HEIGHT_W'(1) : cfg_h_raw;
                default: ;
            endcase
        end
    end

    // Geometry helpers
    assign x_eff   = (WCMP_W'(r_col) >= r_w) ? '0 : r_col;
    assign w_m1    = LB_AW'(r_w - WCMP_W'(1));
    assign h_ext   = ROW_W'(r_h);
    assign col_inc = WCMP_W'(r_x) + WCMP_W'(1);

    // Output pixel for this transaction: one row up and one to the left, or at column zero the right edge two rows up
    always_comb begin
        if (r_x == '0) begin
            n_ox      = w_m1;
            n_oy      = r_y - ROW_W'(2);
            n_has_out = (r_y >= ROW_W'(2));
        end else begin
            n_ox      = r_x - LB_AW'(1);
            n_oy      = r_y - ROW_W'(1);
            n_has_out = (r_y != '0);
        end
        n_last = n_has_out && (n_ox == w_m1) && (n_oy == h_ext - ROW_W'(1));
    end

    // Capture transaction, advance position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we && (i_cfg_index == REG_IMAGE_WIDTH ||
                                  i_cfg_index == REG_IMAGE_HEIGHT)) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.shift) begin
            priority if (n_last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (col_inc >= r_w) begin
                r_col <= '0;
                r_row <= r_y + ROW_W'(1);
            end else begin
                r_col <= LB_AW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= x_eff;
            r_y <= r_row;
            r_v <= (i_in_data.func == FUNC_PIXEL && r_row < h_ext) ? i_in_data.red : '0;
        end
    end

    // Line buffer: row above
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_one_rd <= r_lb_one[x_eff];
        end
        if (i_cmd.shift) begin
            r_lb_one[r_x] <= r_v;
        end
    end

    // Line buffer: two rows above
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_two_rd <= r_lb_two[x_eff];
        end
        if (i_cmd.shift) begin
            r_lb_two[r_x] <= r_one_rd;
        end
    end

    // Window shift: new column enters on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_two_rd;
            r_win[1][2] <= r_one_rd;
            r_win[2][2] <= r_v;
        end
    end

    // Output coordinates for masking and the last flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_last <= n_last;
        end
    end

    // Tap decode
    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            tap_arr[k] = r_taps[k*TAP_BITS +: TAP_BITS];
        end
    end

    // Neighbours outside the image are masked
    assign row_ok[0] = (r_oy != '0);
    assign row_ok[1] = (r_oy < h_ext);
    assign row_ok[2] = ((r_oy + ROW_W'(1)) < h_ext);
    assign col_ok[0] = (r_ox != '0);
    assign col_ok[1] = 1'b1;
    assign col_ok[2] = ((WCMP_W'(r_ox) + WCMP_W'(1)) < r_w);

    assign pix_sel = (row_ok[r_tr] && col_ok[r_tc]) ? r_win[r_tr][r_tc] : '0;
    assign term    = $signed({1'b0, pix_sel}) * tap_arr[r_k];

    // Shared multiply-accumulate, one tap per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_tr <= '0;
            r_tc <= '0;
        end else if (i_cmd.shift) begin
            r_k  <= '0;
            r_tr <= '0;
            r_tc <= '0;
        end else if (i_cmd.mac) begin
            r_k <= r_k + K_W'(1);
            if (r_tc == 2'd2) begin
                r_tc <= '0;
                r_tr <= r_tr + 2'd1;
            end else begin
                r_tc <= r_tc + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_acc <= '0;
        end else if (i_cmd.mac) begin
            r_acc <= r_acc + ACC_W'(term);
        end
    end

    // Scale by Q4.12 factor
    assign n_prod = r_acc * r_scale;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_prod <= n_prod;
        end
    end

    // Clamp to 0..255 (truncation toward zero of prod / 4096)
    always_comb begin
        priority if (r_prod[PROD_W-1] || r_prod == '0) begin
            level = '0;
        end else if (|r_prod[PROD_W-2:FRAC_BITS+PIX_W]) begin
            level = PIX_W'(LEVEL_MAX);
        end else begin
            level = r_prod[FRAC_BITS +: PIX_W];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.level         <= level;
            r_out.last_of_image <= r_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    assign o_status.has_out  = n_has_out;
    assign o_status.mac_done = (r_k == K_W'(NUM_TAPS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

/* rtl/conv3x3_clamp_filter.sv */
// ----------------------------------------------------------------------------
// conv3x3_clamp_filter
// Streaming 3x3 convolution of the red channel with Q4.12 scale and clamp.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction at a time. Each result is the
// 3x3 weighted sum around a pixel (outside neighbours count as zero), scaled
// by scale_factor and clamped to 0..255; results run one row plus one pixel
// behind the input, so image_width+1 padding transactions (func = 1) flush the
// tail, and the bottom-right result carries last_of_image. A transaction that
// yields a result occupies the block, until the next acceptance, for the line
// buffer read, the window update, the multiply-accumulate on the single
// shared unit (one tap a cycle), the scale multiply and the output register
// load; a transaction without a result (first row of the image and first
// pixel of the second row) takes only the line buffer read and the window
// update. The emit step waits while the previous result is still held
// on the output. Line buffer contents need no clearing after reset.
// Configuration must be written only while the block is idle; the block does
// not enforce it. Writing image_width or image_height restarts the image.
// ----------------------------------------------------------------------------
module conv3x3_clamp_filter
    import c3cf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    // output stream
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Sequencer
    c3cf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath
    c3cf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

/* rtl/c3cf_checker.sv */
// ----------------------------------------------------------------------------
// c3cf_checker
// Port-level checks on the filter's stream behaviour, bound to the top level.
// ----------------------------------------------------------------------------
module c3cf_checker
    import c3cf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_data
);

    // Held result stays valid until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Held result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // One transaction at a time: busy right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while previous transaction in flight");

    // A fresh result never appears the cycle after an accept
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(i_in_valid && o_in_ready))
        else $error("result appeared too soon after input");

endmodule

bind conv3x3_clamp_filter c3cf_checker u_checker (.*);

/* tb/sv/conv3x3_clamp_filter_tb.sv */
// ----------------------------------------------------------------------------
// conv3x3_clamp_filter_tb
// Self-checking testbench for the streaming 3x3 clamp filter.
// ----------------------------------------------------------------------------
// A predictor class keeps its own copy of the line buffers, the 3x3 window,
// the raster position and the registers. Every accepted input transaction is
// run through it, and the level it works out is queued. Each output
// transaction is checked field by field against the oldest queued level.
// The run starts with two tiny hand-built images. Random phases follow, each
// with fresh register settings, including extreme taps, scales and geometry.
// Both sides insert random idle cycles, and the receiver stalls once for a
// long stretch while the sender keeps offering transactions.
// ----------------------------------------------------------------------------
module conv3x3_clamp_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c3cf_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 900;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    // ------------------------------------------------------------------------
    // Level predictor: tracks the filter state and queues expected levels
    // ------------------------------------------------------------------------
    class level_predictor;
        logic [TAPS_W-1:0]   taps_q;
        logic [SCALE_W-1:0]  scale_q;
        logic [CFG_W_W-1:0]  width_q;
        logic [HEIGHT_W-1:0] height_q;
        bit [PIX_W-1:0]      line_prev  [MAX_WIDTH];
        bit [PIX_W-1:0]      line_prev2 [MAX_WIDTH];
        bit [PIX_W-1:0]      window [3][3];
        int unsigned         col_pos;
        int unsigned         row_pos;
        t_out_item           levels_due [$];
        int unsigned         n_errors;

        function new();
            taps_q   = TAPS_RST;
            scale_q  = SCALE_RST;
            width_q  = CFG_W_W'(WIDTH_RST);
            height_q = HEIGHT_RST;
            col_pos  = 0;
            row_pos  = 0;
            n_errors = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_KERNEL_TAPS:  taps_q = value[TAPS_W-1:0];
                REG_SCALE_FACTOR: scale_q = value[SCALE_W-1:0];
                REG_IMAGE_WIDTH: begin
                    width_q = value[CFG_W_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
                REG_IMAGE_HEIGHT: begin
                    height_q = value[HEIGHT_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
                default: ;
            endcase
        endfunction

        // signed tap k, row-major
        function int tap(int k);
            bit signed [TAP_BITS-1:0] t;
            t = taps_q[TAP_BITS*k +: TAP_BITS];
            return t;
        endfunction

        // one accepted input transaction
        function void note_pixel(t_in_item it);
            int unsigned     w, h, x, y;
            bit [PIX_W-1:0]  v;
            bit [PIX_W-1:0]  column [3];
            bit [PIX_W-1:0]  view [3][3];
            longint          ox, oy, ty, tx, acc, prod, q;
            t_out_item       res;

            w = (width_q == 0) ? 1 : (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
            h = (height_q == 0) ? 1 : height_q;
            x = (col_pos >= w) ? 0 : col_pos;
            y = row_pos;
            // padding inside the image is a zero pixel; pixels after it are ignored
            v = (it.func == FUNC_PIXEL && y < h) ? it.red : '0;

            column[0]     = line_prev2[x];
            column[1]     = line_prev[x];
            column[2]     = v;
            line_prev2[x] = column[1];
            line_prev[x]  = v;

            // at column zero the output is the last pixel of the row two above
            if (x == 0) begin
                for (int r = 0; r < 3; r++) begin
                    view[r][0] = window[r][1];
                    view[r][1] = window[r][2];
                    view[r][2] = '0;
                end
                ox = longint'(w) - 1;
                oy = longint'(y) - 2;
            end else begin
                ox = longint'(x) - 1;
                oy = longint'(y) - 1;
            end
            for (int r = 0; r < 3; r++) begin
                window[r][0] = window[r][1];
                window[r][1] = window[r][2];
                window[r][2] = column[r];
            end
            if (x != 0) view = window;

            col_pos = x + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = y + 1;
            end

            if (oy < 0) return;

            // weighted sum with outside neighbours masked
            acc = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    ty = oy - 1 + r;
                    tx = ox - 1 + c;
                    if (ty >= 0 && ty < longint'(h) && tx >= 0 && tx < longint'(w))
                        acc += longint'(view[r][c]) * tap(r * 3 + c);
                end
            end
            prod = acc * longint'($signed(scale_q));
            if (prod <= 0) begin
                res.level = '0;
            end else begin
                q = prod >>> FRAC_BITS;
                res.level = (q > LEVEL_MAX) ? PIX_W'(LEVEL_MAX) : PIX_W'(q);
            end
            res.last_of_image = (ox == longint'(w) - 1) && (oy == longint'(h) - 1);
            if (res.last_of_image) begin
                col_pos = 0;
                row_pos = 0;
            end
            levels_due.push_back(res);
        endfunction

        // one accepted output transaction
        function void check_level(t_out_item got);
            t_out_item exp_item;
            if (levels_due.size() == 0) begin
                $error("unexpected output: level %0d, last_of_image %0b",
                       got.level, got.last_of_image);
                n_errors++;
                return;
            end
            exp_item = levels_due.pop_front();
            if (got.level !== exp_item.level) begin
                $error("level: expected %0d, got %0d", exp_item.level, got.level);
                n_errors++;
            end
            if (got.last_of_image !== exp_item.last_of_image) begin
                $error("last_of_image: expected %0b, got %0b",
                       exp_item.last_of_image, got.last_of_image);
                n_errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------------
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    t_out_item             out_data;

    level_predictor pred = new();
    bit             sender_burst;
    bit             hold_req;
    int unsigned    cycle_count;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    conv3x3_clamp_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    function automatic logic [TAPS_W-1:0] pack_taps(input int t [NUM_TAPS]);
        logic [TAPS_W-1:0] packed_taps;
        for (int k = 0; k < NUM_TAPS; k++)
            packed_taps[TAP_BITS*k +: TAP_BITS] = TAP_BITS'(t[k]);
        return packed_taps;
    endfunction

    // write enable stays high across back-to-back writes
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        pred.write_reg(idx, value);
    endtask

    task automatic program_regs(input logic [TAPS_W-1:0] taps,
                                input logic [SCALE_W-1:0] scale,
                                input logic [CFG_W_W-1:0] width,
                                input logic [HEIGHT_W-1:0] height,
                                input bit geometry);
        write_reg(REG_KERNEL_TAPS, CFG_DATA_W'(taps));
        write_reg(REG_SCALE_FACTOR, CFG_DATA_W'(scale));
        if (geometry) begin
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(width));
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(height));
        end
        cfg_we <= 1'b0;
    endtask

    // offer one transaction after a random gap and wait for acceptance
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        pred.note_pixel(it);
    endtask

    // image body mostly pixels, flush tail mostly padding
    task automatic send_image(input int unsigned pixels, input int unsigned flush);
        t_in_item it;
        for (int unsigned i = 0; i < pixels + flush; i++) begin
            it.red = PIX_W'($urandom);
            if (i < pixels)
                it.func = ($urandom_range(0, 9) == 0) ? FUNC_PAD : FUNC_PIXEL;
            else
                it.func = ($urandom_range(0, 4) == 0) ? FUNC_PIXEL : FUNC_PAD;
            send_item(it);
        end
    endtask

    // stop offering, wait for every expected level, then let the block go idle
    task automatic settle();
        in_valid <= 1'b0;
        while (pred.levels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall;
        bit          recv_burst;
        recv_burst = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ready && out_valid) begin
                pred.check_level(out_data);
                if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
                stall = recv_burst ? 0 : $urandom_range(0, 5);
                if (hold_req) begin
                    stall    = HOLD_CYCLES;
                    hold_req = 1'b0;
                end
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** conv3x3_clamp_filter: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        bit [PIX_W-1:0]      first_reds [9];
        int                  t [NUM_TAPS];
        logic [TAPS_W-1:0]   taps;
        logic [SCALE_W-1:0]  scale;
        logic [CFG_W_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        int unsigned         eff_w, eff_h, flush, n_small, phase;
        bit                  geometry;

        first_reds = '{8'd255, 8'd0, 8'd255, 8'hA5, 8'd255, 8'd128, 8'd1, 8'd254, 8'd255};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 image, mixed-sign taps; a padding tick inside the image and a
        // pixel inside the flush
        sender_burst = 1'b0;
        program_regs(pack_taps('{-64, 1, 63, 2, 5, -3, 63, -64, 1}), SCALE_W'(24),
                     CFG_W_W'(3), HEIGHT_W'(3), 1'b1);
        for (int i = 0; i < 9; i++)
            send_item('{(i == 3) ? FUNC_PAD : FUNC_PIXEL, first_reds[i]});
        send_item('{FUNC_PAD, 8'h00});
        send_item('{FUNC_PIXEL, 8'hFF});
        send_item('{FUNC_PAD, 8'h5A});
        send_item('{FUNC_PAD, 8'h00});
        settle();

        // zero width acts as one column; largest taps and scale saturate
        program_regs(pack_taps('{63, 63, 63, 63, 63, 63, 63, 63, 63}), 16'h7FFF,
                     CFG_W_W'(0), HEIGHT_W'(2), 1'b1);
        send_item('{FUNC_PIXEL, 8'd255});
        send_item('{FUNC_PIXEL, 8'd17});
        send_item('{FUNC_PAD, 8'h00});
        send_item('{FUNC_PAD, 8'h00});
        settle();

        // random phases, extreme settings first
        eff_w   = 1;
        eff_h   = 2;
        n_small = 0;
        phase   = 0;
        while (n_small < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 0) begin
                taps = TAPS_W'({$urandom, $urandom});
            end else begin
                for (int k = 0; k < NUM_TAPS; k++) t[k] = int'($urandom_range(0, 8)) - 4;
                taps = pack_taps(t);
            end
            scale    = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom)
                                                   : SCALE_W'($urandom_range(0, 2048));
            width    = ($urandom_range(0, 7) == 0) ? CFG_W_W'($urandom_range(9, 40))
                                                   : CFG_W_W'($urandom_range(0, 8));
            height   = HEIGHT_W'($urandom_range(0, 6));
            geometry = (phase < 5) || ($urandom_range(0, 3) != 0);
            case (phase)
                0: begin
                    width  = CFG_W_W'(5);
                    height = '1;
                end
                1: begin
                    width  = CFG_W_W'($urandom_range(41, 120));
                    height = '0;
                end
                2: begin
                    taps  = pack_taps('{-64, -64, -64, -64, -64, -64, -64, -64, -64});
                    scale = 16'h8000;
                end
                3: begin
                    taps  = pack_taps('{63, 63, 63, 63, 63, 63, 63, 63, 63});
                    scale = 16'h7FFF;
                end
                4: scale = '0;
                default: ;
            endcase
            program_regs(taps, scale, width, height, geometry);
            if (geometry) begin
                eff_w = (width == 0) ? 1 : (width > MAX_WIDTH) ? MAX_WIDTH : width;
                eff_h = (height == 0) ? 1 : height;
            end
            sender_burst = ($urandom_range(0, 3) == 0);

            if (phase == 0) begin
                // tall image cut short; receiver holds off while input backs up
                hold_req = 1'b1;
                send_image(60, 0);
                n_small += 60;
            end else if (phase == 1) begin
                // wide image, single row
                send_image(eff_w, eff_w + 1);
                n_small += 2 * eff_w + 1;
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    flush = eff_w + 1;
                    case ($urandom_range(0, 5))
                        0: flush = $urandom_range(0, eff_w);
                        1: flush += $urandom_range(1, 3);
                        default: ;
                    endcase
                    send_image(eff_w * eff_h, flush);
                    n_small += eff_w * eff_h + flush;
                end
            end
            settle();
            phase++;
        end

        if (pred.levels_due.size() != 0) begin
            $error("%0d expected levels never arrived", pred.levels_due.size());
            pred.n_errors++;
        end
        if (pred.n_errors == 0) begin
            $display("** conv3x3_clamp_filter: PASSED **");
        end else begin
            $display("** conv3x3_clamp_filter: FAILED **");
        end
        $finish;
    end

endmodule
